/* rtl/srma_pkg.sv */
package srma_pkg;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned MAX_STEMS = 4;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned SUM_W     = SQ_W + 2;
  localparam int unsigned QBITS     = 17;
  localparam int unsigned BIN_W     = 32;
  localparam int unsigned PROD_W    = BIN_W + QBITS + 1;
  localparam int unsigned RND_SHIFT = 16;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CIDX_W    = 2;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  // word index of num_stems (paddr[2])
  localparam logic REG_NUM_STEMS = 1'b0;
  localparam logic [CNT_W-1:0] NUM_STEMS_RST = 3'd4;

  typedef logic [QBITS-1:0] mask_t;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [SLOTS-1:0]        act;
    logic                    zero;
    logic [CIDX_W-1:0]       cidx;
  } side_t;

  // equal split when every square is zero: 65536 / active count
  function automatic mask_t zero_mask(input logic [CIDX_W-1:0] cidx);
    mask_t m;
    case (cidx)
      2'd0:    m = 17'd65536;
      2'd1:    m = 17'd32768;
      2'd2:    m = 17'd21845;
      default: m = 17'd16384;
    endcase
    return m;
  endfunction

endpackage

/* rtl/srma_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Quotient of (sq << 16) / den, known to be below 2^17.
module srma_div (
  input  logic                             clk_i,
  input  logic [srma_pkg::QBITS-1:0]       en_i,
  input  logic [srma_pkg::SQ_W-1:0]        sq_i,
  input  logic [srma_pkg::SUM_W-1:0]       den_i,
  output logic [srma_pkg::QBITS-1:0]       quo_o
);

  localparam int unsigned QB = srma_pkg::QBITS;
  localparam int unsigned SW = srma_pkg::SUM_W;

  logic [SW-1:0] rem_q [QB-1];
  logic [SW-1:0] den_q [QB-1];
  logic [QB-1:0] quo_q [QB];

  genvar j;
  generate
    for (j = 0; j < QB; j++) begin : g_stage
      logic [SW:0]   trial;
      logic [SW:0]   diff;
      logic [SW-1:0] dcur;
      logic [QB-1:0] qprev;
      logic          take;

      if (j == 0) begin : g_first
        // first trial is sq itself: sq >> 1 with sq[0] shifted back in
        assign trial = (SW+1)'(sq_i);
        assign dcur  = den_i;
        assign qprev = '0;
      end else begin : g_next
        assign trial = {rem_q[j-1], 1'b0};
        assign dcur  = den_q[j-1];
        assign qprev = quo_q[j-1];
      end

      assign diff = trial - {1'b0, dcur};
      assign take = (trial >= {1'b0, dcur});

      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          quo_q[j] <= {qprev[QB-2:0], take};
        end
      end

      if (j < QB - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i[j]) begin
            rem_q[j] <= take ? diff[SW-1:0] : trial[SW-1:0];
            den_q[j] <= dcur;
          end
        end
      end
    end
  endgenerate

  assign quo_o = quo_q[QB-1];

endmodule

/* rtl/stem_ratio_mask_apply.sv */
// Channel  | Handshake                     | Words
// ---------+-------------------------------+---------------------------------------
// in       | in_valid_i / in_stall_o       | stem0..3_magnitude_i, bin_real/imag_i
// out      | out_valid_o / out_stall_i     | stem0..3_real_o, stem0..3_imag_o
// config   | psel/penable/pwrite/pready    | paddr, pwdata, prdata (num_stems)
//
// One word per cycle sustained while out_stall_i stays low.
// Depth is set by the divider: 17 stages, one mask bit per stage, per stem.
// Stages: square, sum, 17 x divide, mask select, multiply, round/output.
// Each stage holds its word until the next stage frees up, so bubbles close
// up under out_stall_i and new words enter while results wait.
// Reset clears the valid bits and sets num_stems to 4.
module stem_ratio_mask_apply (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srma_pkg::ADDR_W-1:0]         paddr,
  input  logic [srma_pkg::DATA_W-1:0]         pwdata,
  output logic [srma_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [srma_pkg::MAG_W-1:0]          stem0_magnitude_i,
  input  logic [srma_pkg::MAG_W-1:0]          stem1_magnitude_i,
  input  logic [srma_pkg::MAG_W-1:0]          stem2_magnitude_i,
  input  logic [srma_pkg::MAG_W-1:0]          stem3_magnitude_i,
  input  logic signed [srma_pkg::BIN_W-1:0]   bin_real_i,
  input  logic signed [srma_pkg::BIN_W-1:0]   bin_imag_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [srma_pkg::BIN_W-1:0]   stem0_real_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem0_imag_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem1_real_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem1_imag_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem2_real_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem2_imag_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem3_real_o,
  output logic signed [srma_pkg::BIN_W-1:0]   stem3_imag_o
);

  localparam int unsigned SLOTS   = srma_pkg::SLOTS;
  localparam int unsigned QBITS   = srma_pkg::QBITS;
  localparam int unsigned SQ_W    = srma_pkg::SQ_W;
  localparam int unsigned SUM_W   = srma_pkg::SUM_W;
  localparam int unsigned BIN_W   = srma_pkg::BIN_W;
  localparam int unsigned PROD_W  = srma_pkg::PROD_W;
  localparam int unsigned CNT_W   = srma_pkg::CNT_W;
  localparam int unsigned CIDX_W  = srma_pkg::CIDX_W;

  localparam int unsigned ST_SQ   = 0;
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_DIV0 = 2;
  localparam int unsigned ST_DIVN = ST_DIV0 + QBITS - 1;
  localparam int unsigned ST_MASK = ST_DIVN + 1;
  localparam int unsigned ST_MUL  = ST_MASK + 1;
  localparam int unsigned ST_OUT  = ST_MUL + 1;
  localparam int unsigned NSTG    = ST_OUT + 1;

  // ---------------- configuration ----------------
  logic [CNT_W-1:0] num_stems_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == srma_pkg::REG_NUM_STEMS);
  assign prdata = (paddr[2] == srma_pkg::REG_NUM_STEMS) ? srma_pkg::DATA_W'(num_stems_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_stems_q <= srma_pkg::NUM_STEMS_RST;
    end else if (cfg_wr) begin
      num_stems_q <= pwdata[CNT_W-1:0];
    end
  end

  logic [CNT_W-1:0]  n_eff;
  logic [SLOTS-1:0]  act_in;

  always_comb begin
    n_eff = num_stems_q;
    if (n_eff == '0) begin
      n_eff = CNT_W'(1);
    end
    if (n_eff > CNT_W'(srma_pkg::MAX_STEMS)) begin
      n_eff = CNT_W'(srma_pkg::MAX_STEMS);
    end
    for (int s = 0; s < SLOTS; s++) begin
      act_in[s] = (CNT_W'(s) < n_eff);
    end
  end

  // ---------------- stage flow control ----------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;

  assign rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
  genvar k;
  generate
    for (k = 0; k < NSTG - 1; k++) begin : g_rdy
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end
  endgenerate

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------- datapath ----------------
  logic [srma_pkg::MAG_W-1:0] mag [SLOTS];
  assign mag[0] = stem0_magnitude_i;
  assign mag[1] = stem1_magnitude_i;
  assign mag[2] = stem2_magnitude_i;
  assign mag[3] = stem3_magnitude_i;

  srma_pkg::side_t side_q [ST_DIVN+1];
  logic [SQ_W-1:0]  sq0_q [SLOTS];
  logic [SQ_W-1:0]  sq1_q [SLOTS];
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  srma_pkg::side_t  side_sum_d;
  logic [QBITS-1:0] quo [SLOTS];

  srma_pkg::mask_t         mask_q [SLOTS];
  logic signed [BIN_W-1:0] re_m_q, im_m_q;
  logic signed [PROD_W-1:0] pre_q [SLOTS];
  logic signed [PROD_W-1:0] pim_q [SLOTS];
  logic signed [PROD_W-1:0] rre [SLOTS];
  logic signed [PROD_W-1:0] rim [SLOTS];
  logic signed [BIN_W-1:0] ore_q [SLOTS];
  logic signed [BIN_W-1:0] oim_q [SLOTS];

  always_comb begin
    sum_d = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (side_q[ST_SQ].act[s]) begin
        sum_d = sum_d + SUM_W'(sq0_q[s]);
      end
    end
    side_sum_d      = side_q[ST_SQ];
    side_sum_d.zero = (sum_d == '0);
  end

  always_ff @(posedge clk_i) begin
    // square
    if (rdy[ST_SQ]) begin
      for (int s = 0; s < SLOTS; s++) begin
        sq0_q[s] <= mag[s] * mag[s];
      end
      side_q[ST_SQ].re   <= bin_real_i;
      side_q[ST_SQ].im   <= bin_imag_i;
      side_q[ST_SQ].act  <= act_in;
      side_q[ST_SQ].zero <= 1'b0;
      side_q[ST_SQ].cidx <= CIDX_W'(n_eff - CNT_W'(1));
    end
    // sum of active squares
    if (rdy[ST_SUM]) begin
      sq1_q <= sq0_q;
      sum_q <= sum_d;
      side_q[ST_SUM] <= side_sum_d;
    end
    // side data rides along the divider
    for (int i = ST_DIV0; i <= ST_DIVN; i++) begin
      if (rdy[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
    // mask select
    if (rdy[ST_MASK]) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!side_q[ST_DIVN].act[s]) begin
          mask_q[s] <= '0;
        end else if (side_q[ST_DIVN].zero) begin
          mask_q[s] <= srma_pkg::zero_mask(side_q[ST_DIVN].cidx);
        end else begin
          mask_q[s] <= quo[s];
        end
      end
      re_m_q <= side_q[ST_DIVN].re;
      im_m_q <= side_q[ST_DIVN].im;
    end
    // multiply
    if (rdy[ST_MUL]) begin
      for (int s = 0; s < SLOTS; s++) begin
        pre_q[s] <= re_m_q * $signed({1'b0, mask_q[s]});
        pim_q[s] <= im_m_q * $signed({1'b0, mask_q[s]});
      end
    end
    // round half up and shift
    if (rdy[ST_OUT]) begin
      for (int s = 0; s < SLOTS; s++) begin
        ore_q[s] <= rre[s][srma_pkg::RND_SHIFT +: BIN_W];
        oim_q[s] <= rim[s][srma_pkg::RND_SHIFT +: BIN_W];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      rre[s] = pre_q[s] + PROD_W'(1 << (srma_pkg::RND_SHIFT - 1));
      rim[s] = pim_q[s] + PROD_W'(1 << (srma_pkg::RND_SHIFT - 1));
    end
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_div
      srma_div u_div (
        .clk_i (clk_i),
        .en_i  (rdy[ST_DIVN:ST_DIV0]),
        .sq_i  (sq1_q[g]),
        .den_i (sum_q),
        .quo_o (quo[g])
      );
    end
  endgenerate

  assign stem0_real_o = ore_q[0];
  assign stem0_imag_o = oim_q[0];
  assign stem1_real_o = ore_q[1];
  assign stem1_imag_o = oim_q[1];
  assign stem2_real_o = ore_q[2];
  assign stem2_imag_o = oim_q[2];
  assign stem3_real_o = ore_q[3];
  assign stem3_imag_o = oim_q[3];

endmodule

/* test/stem_ratio_mask_check.sv */
`timescale 1ns / 1ps

module stem_ratio_mask_check
  import srma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,

  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [MAG_W-1:0]         stem0_magnitude_i,
  input  logic [MAG_W-1:0]         stem1_magnitude_i,
  input  logic [MAG_W-1:0]         stem2_magnitude_i,
  input  logic [MAG_W-1:0]         stem3_magnitude_i,
  input  logic signed [BIN_W-1:0]  bin_real_i,
  input  logic signed [BIN_W-1:0]  bin_imag_i,

  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic signed [BIN_W-1:0]  stem0_real_o,
  input  logic signed [BIN_W-1:0]  stem0_imag_o,
  input  logic signed [BIN_W-1:0]  stem1_real_o,
  input  logic signed [BIN_W-1:0]  stem1_imag_o,
  input  logic signed [BIN_W-1:0]  stem2_real_o,
  input  logic signed [BIN_W-1:0]  stem2_imag_o,
  input  logic signed [BIN_W-1:0]  stem3_real_o,
  input  logic signed [BIN_W-1:0]  stem3_imag_o,

  output int unsigned              mismatches_o,
  output int unsigned              pending_o
);

  localparam longint unsigned UNITY_MASK = 64'd1 << RND_SHIFT;

  typedef struct packed {
    logic [SLOTS-1:0][BIN_W-1:0] re;
    logic [SLOTS-1:0][BIN_W-1:0] im;
  } stem_bins_t;

  logic [CNT_W-1:0] stem_count;
  stem_bins_t       bins_due [$];
  stem_bins_t       got;
  stem_bins_t       want;
  int unsigned      mismatches = 0;

  // (bin * mask + half) >> 16, floor on negatives
  function automatic logic [BIN_W-1:0] scale_bin(input logic signed [BIN_W-1:0] bin,
                                                 input logic [QBITS-1:0] mask);
    longint prod;
    prod = longint'(bin) * longint'(mask) + longint'(UNITY_MASK >> 1);
    return BIN_W'(prod >>> RND_SHIFT);
  endfunction

  function automatic stem_bins_t masked_bins(input logic [CNT_W-1:0] cfg,
                                             input logic [SLOTS-1:0][MAG_W-1:0] mag,
                                             input logic signed [BIN_W-1:0] re,
                                             input logic signed [BIN_W-1:0] im);
    int unsigned      active;
    logic [SQ_W-1:0]  sq [SLOTS];
    logic [63:0]      total;
    logic [QBITS-1:0] mask;
    stem_bins_t       r;
    active = cfg;
    if (active == 0) active = 1;
    if (active > MAX_STEMS) active = MAX_STEMS;
    total = '0;
    for (int s = 0; s < SLOTS; s++) begin
      sq[s] = SQ_W'(mag[s]) * SQ_W'(mag[s]);
      if (s < active) total += 64'(sq[s]);
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (s >= active) begin
        r.re[s] = '0;
        r.im[s] = '0;
      end else begin
        // equal split stands in for the epsilon when nothing has energy
        if (total == 0) mask = QBITS'(UNITY_MASK / active);
        else mask = QBITS'({sq[s], 16'b0} / total);
        r.re[s] = scale_bin(re, mask);
        r.im[s] = scale_bin(im, mask);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stem_count = NUM_STEMS_RST;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_NUM_STEMS, 2'b00}) begin
        stem_count = pwdata[CNT_W-1:0];
      end
      if (in_valid_i && !in_stall_o) begin
        bins_due.push_back(masked_bins(stem_count,
            {stem3_magnitude_i, stem2_magnitude_i, stem1_magnitude_i, stem0_magnitude_i},
            bin_real_i, bin_imag_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got.re = {stem3_real_o, stem2_real_o, stem1_real_o, stem0_real_o};
        got.im = {stem3_imag_o, stem2_imag_o, stem1_imag_o, stem0_imag_o};
        if (bins_due.size() == 0) begin
          mismatches++;
          $display("%0t: output word with no input word pending", $time);
        end else begin
          want = bins_due.pop_front();
          for (int s = 0; s < SLOTS; s++) begin
            if (got.re[s] !== want.re[s]) begin
              mismatches++;
              $display("%0t: stem%0d_real expected %h, got %h",
                       $time, s, want.re[s], got.re[s]);
            end
            if (got.im[s] !== want.im[s]) begin
              mismatches++;
              $display("%0t: stem%0d_imag expected %h, got %h",
                       $time, s, want.im[s], got.im[s]);
            end
          end
        end
      end
    end
    mismatches_o = mismatches;
    pending_o    = bins_due.size();
  end

endmodule

/* test/stem_ratio_mask_apply_test.sv */
`timescale 1ns / 1ps

module stem_ratio_mask_apply_test;
  import srma_pkg::*;

  localparam int unsigned PHASES          = 12;
  localparam int unsigned WORDS_PER_PHASE = 36;
  localparam int unsigned DRAIN_CYCLES    = 30;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                    in_valid_i        = 1'b0;
  logic                    in_stall_o;
  logic [MAG_W-1:0]        stem0_magnitude_i = '0;
  logic [MAG_W-1:0]        stem1_magnitude_i = '0;
  logic [MAG_W-1:0]        stem2_magnitude_i = '0;
  logic [MAG_W-1:0]        stem3_magnitude_i = '0;
  logic signed [BIN_W-1:0] bin_real_i        = '0;
  logic signed [BIN_W-1:0] bin_imag_i        = '0;

  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [BIN_W-1:0] stem0_real_o, stem0_imag_o;
  logic signed [BIN_W-1:0] stem1_real_o, stem1_imag_o;
  logic signed [BIN_W-1:0] stem2_real_o, stem2_imag_o;
  logic signed [BIN_W-1:0] stem3_real_o, stem3_imag_o;

  int unsigned mismatches_o;
  int unsigned pending_o;

  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stem_ratio_mask_apply dut (.*);

  stem_ratio_mask_check check (.*);

  function automatic logic [BIN_W-1:0] rand_bin();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return BIN_W'($urandom_range(0, 2048)) - 32'd1024;
      default: return $urandom();
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic send_bin(input logic [MAG_W-1:0] m0, input logic [MAG_W-1:0] m1,
                          input logic [MAG_W-1:0] m2, input logic [MAG_W-1:0] m3,
                          input logic [BIN_W-1:0] re, input logic [BIN_W-1:0] im);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    stem0_magnitude_i = m0;
    stem1_magnitude_i = m1;
    stem2_magnitude_i = m2;
    stem3_magnitude_i = m3;
    bin_real_i        = re;
    bin_imag_i        = im;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // output side: random stall ahead of every word
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(0, rx_gap_max);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CNT_W-1:0]            stem_cfgs [8];
    logic [CNT_W-1:0]            cfg;
    logic [SLOTS-1:0][MAG_W-1:0] mag;
    int unsigned                 quiet;
    stem_cfgs = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // corner words at the reset stem count of four
    tx_gap_max = 3;
    rx_gap_max = 10;
    send_bin('0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin('0, '0, '0, '0, 32'hFFFF_FFFF, 32'd1);
    send_bin('0, '0, '0, '0, 32'd3, -32'sd3);
    send_bin('1, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_bin('1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(24'd1, 24'd1, '0, '0, 32'd1, -32'sd1);
    send_bin(24'd1, 24'd1, '0, '0, 32'd3, -32'sd3);
    send_bin(24'd1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(24'd3, 24'd3, 24'd3, '0, 32'h1234_5678, -32'sd99);
    send_bin('1, '1, '1, 24'd1, 32'h8000_0000, 32'h8000_0000);
    send_bin('0, '0, '0, '1, 32'h8000_0000, 32'h8000_0000);
    send_bin(24'd5, '0, 24'd7, '0, '0, '0);
    send_bin(24'd1, 24'd2, 24'd3, 24'd4, 32'd12345, -32'sd67890);

    for (int p = 0; p < PHASES; p++) begin
      // stem count changes only with nothing in flight
      in_valid_i = 1'b0;
      while (pending_o != 0) @(negedge clk_i);
      cfg = (p < 8) ? stem_cfgs[p] : CNT_W'($urandom_range(0, 7));
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {REG_NUM_STEMS, 2'b00};
      pwdata  = {29'($urandom()), cfg};
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;

      // mix of back-to-back, heavy idling and light idling on each side
      tx_gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 3);
      rx_gap_max = (p % 3 == 1) ? 0 : ((p % 3 == 2) ? 10 : 3);

      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        for (int s = 0; s < SLOTS; s++) begin
          case ($urandom_range(0, 5))
            0:       mag[s] = '0;
            1:       mag[s] = '1;
            2:       mag[s] = MAG_W'($urandom_range(0, 255));
            default: mag[s] = MAG_W'($urandom());
          endcase
        end
        // silence the leading stems now and then to hit the equal split
        if ($urandom_range(0, 7) == 0) begin
          quiet = $urandom_range(1, SLOTS);
          for (int s = 0; s < SLOTS; s++) begin
            if (s < quiet) mag[s] = '0;
          end
        end
        send_bin(mag[0], mag[1], mag[2], mag[3], rand_bin(), rand_bin());
      end
    end

    in_valid_i = 1'b0;
    while (pending_o != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches_o == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/srma_pkg.sv
rtl/srma_div.sv
rtl/stem_ratio_mask_apply.sv
test/stem_ratio_mask_check.sv
test/stem_ratio_mask_apply_test.sv
